@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the checker module
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with asynchronous active-low reset disable
`define AST_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// implication on the same clock: antecedent holds, consequent must hold too
`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	`AST_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

// implication on the following clock
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`AST_CLK(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/maj_pkg.sv @@
// ---------------------------------------------------------------------------
// maj_pkg
// Types, codes and defaults shared by the majority element finder
// ---------------------------------------------------------------------------
package maj_pkg;

	// width of the value fields on the ports
	localparam int ITEM_W = 32;

	// parameter defaults
	localparam int MAX_ITEMS_DEF  = 1024;
	localparam int DATA_WIDTH_DEF = 32;

	// one input transfer
	typedef struct packed {
		logic signed [ITEM_W-1:0] item_value;
		logic                     is_last;
	} item_t;

	// one result transfer
	typedef struct packed {
		logic                     has_majority;
		logic signed [ITEM_W-1:0] majority_value;
		logic                     overflowed;
	} result_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DONE
	} state_t;

	// operations of the shared compare unit
	typedef enum logic [1:0] {
		OP_NONE,
		OP_VOTE,
		OP_COUNT,
		OP_CLEAR
	} tally_op_t;

	// control from the sequencer to the tally unit
	typedef struct packed {
		tally_op_t op;
	} tally_ctl_t;

endpackage

@@ hw/rtl/majority_element_finder_top.sv @@
// ---------------------------------------------------------------------------
// majority_element_finder_top
// Majority element finder: streaming vote on load, verification scan after
// ---------------------------------------------------------------------------
// Items of a set are taken one per cycle; the item flagged is_last closes the
// set. While loading, each item is written to the store and a single-candidate
// vote is updated. After the last transfer, the input stalls while the store
// is scanned once through its single read port, one item per cycle, counting
// the candidate's occurrences. The result sits in an output register, so
// loading of the next set may start while it waits. Items that arrive when
// MAX_ITEMS are stored are dropped and flagged in overflowed; the majority is
// then judged over the stored items only. Values are kept in their low
// DATA_WIDTH bits and the reported value is sign-extended from that width.
// The store has no reset.
// ---------------------------------------------------------------------------
module majority_element_finder_top #(
	parameter int MAX_ITEMS  = maj_pkg::MAX_ITEMS_DEF,
	parameter int DATA_WIDTH = maj_pkg::DATA_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  maj_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output maj_pkg::result_t result
);
	import maj_pkg::*;

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int EW = (DATA_WIDTH > ITEM_W) ? DATA_WIDTH : ITEM_W;

	state_t               state_q, state_d;
	tally_ctl_t           ctl;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        scan_q;
	logic                 ovf_q;
	logic                 rd_valid_s1;
	logic                 result_valid_q;
	result_t              result_q;
	logic                 full;
	logic                 store_we;
	logic                 scan_issue;
	logic                 result_load;
	logic signed [EW-1:0] in_ext;
	logic [DATA_WIDTH-1:0] in_word;
	logic [DATA_WIDTH-1:0] rd_word;
	logic [DATA_WIDTH-1:0] cand;
	logic signed [EW-1:0] cand_ext;
	logic [CW-1:0]        occ;
	logic                 has_maj;

	// input value reduced to the stored width
	assign in_ext  = EW'(item.item_value);
	assign in_word = in_ext[DATA_WIDTH-1:0];

	assign full       = (count_q == CW'(MAX_ITEMS));
	assign item_ready = (state_q == ST_LOAD);

	// sequencer next state and control
	always_comb begin
		state_d     = state_q;
		ctl.op      = OP_NONE;
		store_we    = 1'b0;
		scan_issue  = 1'b0;
		result_load = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				if (item_valid) begin
					if (!full) begin
						store_we = 1'b1;
						ctl.op   = OP_VOTE;
					end
					if (item.is_last) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				scan_issue = (scan_q != count_q);
				if (rd_valid_s1) begin
					ctl.op = OP_COUNT;
				end
				if ((scan_q == count_q) && !rd_valid_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					result_load = 1'b1;
					ctl.op      = OP_CLEAR;
					state_d     = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// fill count, overflow flag and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			scan_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= scan_issue;
			if (store_we) begin
				count_q <= count_q + CW'(1);
			end
			if (item_valid && item_ready && full) begin
				ovf_q <= 1'b1;
			end
			if (scan_issue) begin
				scan_q <= scan_q + CW'(1);
			end
			if (result_load) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				scan_q  <= '0;
			end
		end
	end

	// item store
	maj_store #(
		.DEPTH (MAX_ITEMS),
		.DW    (DATA_WIDTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[AW-1:0]),
		.wdata (in_word),
		.re    (scan_issue),
		.raddr (scan_q[AW-1:0]),
		.rdata (rd_word)
	);

	// vote and occurrence count
	maj_tally #(
		.DW (DATA_WIDTH),
		.CW (CW)
	) u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.in_word (in_word),
		.rd_word (rd_word),
		.cand    (cand),
		.occ     (occ)
	);

	// majority test: occurrences more than half of the stored items
	assign has_maj  = ({occ, 1'b0} > {1'b0, count_q});
	assign cand_ext = EW'(signed'(cand));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			result_q.has_majority   <= has_maj;
			result_q.majority_value <= has_maj ? cand_ext[ITEM_W-1:0] : '0;
			result_q.overflowed     <= ovf_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ hw/rtl/maj_store.sv @@
// ---------------------------------------------------------------------------
// maj_store
// Item memory: one write port, one registered read port
// ---------------------------------------------------------------------------
module maj_store #(
	parameter int DEPTH = 1024,
	parameter int DW    = 32,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/maj_tally.sv @@
// ---------------------------------------------------------------------------
// maj_tally
// Candidate vote and occurrence count around one shared equality compare
// ---------------------------------------------------------------------------
module maj_tally #(
	parameter int DW = 32,
	parameter int CW = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  maj_pkg::tally_ctl_t ctl,
	input  logic [DW-1:0]      in_word,
	input  logic [DW-1:0]      rd_word,
	output logic [DW-1:0]      cand,
	output logic [CW-1:0]      occ
);
	import maj_pkg::*;

	logic [DW-1:0] cand_q;
	logic [CW-1:0] vote_q;
	logic [CW-1:0] occ_q;
	logic [DW-1:0] opnd;
	logic          eq;

	// shared compare: incoming item while loading, stored item while scanning
	assign opnd = (ctl.op == OP_COUNT) ? rd_word : in_word;
	assign eq   = (opnd == cand_q);

	// vote and occurrence registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			vote_q <= '0;
			occ_q  <= '0;
		end else begin
			unique case (ctl.op)
				OP_VOTE: begin
					if (vote_q == '0) begin
						cand_q <= in_word;
						vote_q <= CW'(1);
					end else if (eq) begin
						vote_q <= vote_q + CW'(1);
					end else begin
						vote_q <= vote_q - CW'(1);
					end
				end
				OP_COUNT: begin
					if (eq) begin
						occ_q <= occ_q + CW'(1);
					end
				end
				OP_CLEAR: begin
					cand_q <= '0;
					vote_q <= '0;
					occ_q  <= '0;
				end
				OP_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign cand = cand_q;
	assign occ  = occ_q;

endmodule

@@ hw/rtl/majority_element_finder_chk.sv @@
// ---------------------------------------------------------------------------
// majority_element_finder_chk
// Port-level checks on the majority element finder, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module majority_element_finder_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input maj_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_ready,
	input maj_pkg::result_t result
);
	import maj_pkg::*;

	// a stalled result holds
	`AST_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

	// no majority reports a zero value
	`AST_IMPL(a_no_maj_zero, clk, arst_n, result_valid && !result.has_majority, result.majority_value == '0, "value not zero without majority")

	// the closing transfer of a set starts the scan and stalls the input
	`AST_NEXT(a_last_stalls, clk, arst_n, item_valid && item_ready && item.is_last, !item_ready, "input not stalled after last transfer")

	// a new result only follows a scan, when the input was stalled
	`AST_IMPL(a_result_after_scan, clk, arst_n, $rose(result_valid), $past(!item_ready), "result without preceding scan")

endmodule

bind majority_element_finder_top majority_element_finder_chk u_chk (.*);

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the majority element finder
// ---------------------------------------------------------------------------
// Sets of values are queued as item transfers and driven with random gaps.
// Each accepted item updates a local vote-and-count model. Each set's closing
// item yields one expected verdict. Every result transfer is checked field by
// field against the oldest pending verdict. The run covers directed corner
// sets, one long receiver hold-off and four idling phases. Each phase pauses
// the sender once until all verdicts are in.
// ---------------------------------------------------------------------------
module tb_top;
	import maj_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 64;

	// kinds of generated sets
	typedef enum int {
		MIX_POOL,
		MIX_PLANTED,
		MIX_HALF,
		MIX_WIDE
	} mix_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_ready;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// pending item transfers and expected verdicts
	item_t   pend_q[$];
	result_t majority_q[$];

	// local copy of the set state
	logic [ITEM_W-1:0] stored_q[$];
	logic [ITEM_W-1:0] cand    = '0;
	int                votes   = 0;
	logic              dropped = 1'b0;

	// set builder scratch
	logic [ITEM_W-1:0] set_buf[$];
	logic [ITEM_W-1:0] plant_val;

	int   idle_pct  = 0;
	int   stall_pct = 0;
	int   fails     = 0;
	int   cycles    = 0;
	int   hold_cnt  = 0;
	logic hold_req  = 1'b0;
	logic hold_ack  = 1'b0;

	majority_element_finder_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// vote on each stored item, count the candidate when the set closes
	task automatic tally_item(input item_t it);
		logic [ITEM_W-1:0] v;
		int                hits;
		result_t           r;
		v = it.item_value;
		if (stored_q.size() < MAX_ITEMS_DEF) begin
			stored_q.push_back(v);
			if (votes == 0) begin
				cand  = v;
				votes = 1;
			end else if (cand == v) begin
				votes++;
			end else begin
				votes--;
			end
		end else begin
			dropped = 1'b1;
		end
		if (it.is_last) begin
			hits = 0;
			foreach (stored_q[k])
				if (stored_q[k] == cand)
					hits++;
			r.has_majority   = (2 * hits > stored_q.size());
			r.majority_value = r.has_majority ? cand : '0;
			r.overflowed     = dropped;
			majority_q.push_back(r);
			stored_q.delete();
			cand    = '0;
			votes   = 0;
			dropped = 1'b0;
		end
	endtask

	// random word, biased toward the extremes
	function automatic logic [ITEM_W-1:0] rand_word();
		case ($urandom_range(7))
			0: rand_word = 32'h8000_0000;
			1: rand_word = 32'h7fff_ffff;
			2: rand_word = '0;
			3: rand_word = '1;
			default: rand_word = $urandom();
		endcase
	endfunction

	// fill set_buf with n values of the given kind, in random order
	task automatic build_set(input int n, input mix_t mode);
		logic [ITEM_W-1:0] pool[3];
		logic [ITEM_W-1:0] tmp;
		int                copies;
		int                j;
		foreach (pool[p])
			pool[p] = rand_word();
		plant_val = rand_word();
		copies    = 0;
		if (mode == MIX_PLANTED)
			copies = $urandom_range(n / 2 + 1, n);
		else if (mode == MIX_HALF)
			copies = n / 2;
		set_buf.delete();
		for (int i = 0; i < n; i++) begin
			if (i < copies)
				set_buf.push_back(plant_val);
			else if (mode == MIX_POOL)
				set_buf.push_back(pool[$urandom_range(2)]);
			else
				set_buf.push_back(rand_word());
		end
		for (int i = n - 1; i > 0; i--) begin
			j          = $urandom_range(i);
			tmp        = set_buf[i];
			set_buf[i] = set_buf[j];
			set_buf[j] = tmp;
		end
	endtask

	// queue set_buf as transfers, flagging the final one
	task automatic send_set();
		item_t it;
		foreach (set_buf[i]) begin
			it.item_value = set_buf[i];
			it.is_last    = (i == set_buf.size() - 1);
			pend_q.push_back(it);
		end
		set_buf.delete();
	endtask

	// queue random sets until about n items are pending
	task automatic send_random(input int n);
		int sent;
		int len;
		sent = 0;
		while (sent < n) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			build_set(len, mix_t'($urandom_range(3)));
			send_set();
			sent += len;
		end
	endtask

	// sender holds back until every verdict has come out
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pend_q.size() != 0 || item_valid || majority_q.size() != 0);
	endtask

	task automatic run_phase(input int idle, input int stall);
		@(negedge clk);
		idle_pct  = idle;
		stall_pct = stall;
		send_random(140);
		wait_drained();
	endtask

	// item driver: hold until accepted, then offer the next or idle
	always @(posedge clk) begin : drive_items
		logic give;
		if (arst_n) begin
			if (item_valid && item_ready)
				tally_item(item);
			if (!item_valid || item_ready) begin
				give = (pend_q.size() != 0) && ($urandom_range(99) >= idle_pct);
				if (give) begin
					item       <= pend_q.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin : hold_timer
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (hold_req != hold_ack) begin
			hold_cnt <= HOLD_CYCLES;
			hold_ack <= hold_req;
		end
	end

	// result monitor: check each transfer against the oldest verdict
	always @(posedge clk) begin : watch_results
		result_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (majority_q.size() == 0) begin
					$display("%0t: unexpected result transfer %h", $time, result);
					fails++;
				end else begin
					want = majority_q.pop_front();
					if (result.has_majority !== want.has_majority) begin
						$display("%0t: has_majority expected %b actual %b", $time,
							want.has_majority, result.has_majority);
						fails++;
					end
					if (result.majority_value !== want.majority_value) begin
						$display("%0t: majority_value expected %h actual %h", $time,
							want.majority_value, result.majority_value);
						fails++;
					end
					if (result.overflowed !== want.overflowed) begin
						$display("%0t: overflowed expected %b actual %b", $time,
							want.overflowed, result.overflowed);
						fails++;
					end
				end
			end
			result_ready <= (hold_cnt == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	// run limit
	always @(posedge clk) begin : watchdog
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// single extremes, all-ones majority, even split, vote switching
		set_buf = {32'h8000_0000};
		send_set();
		set_buf = {32'h7fff_ffff};
		send_set();
		set_buf = {32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000};
		send_set();
		set_buf = {32'h0000_0000, 32'h0000_0001};
		send_set();
		set_buf = {32'h5, 32'h5, 32'h7, 32'h5, 32'h7};
		send_set();
		set_buf = {32'h1, 32'h2, 32'h3};
		send_set();
		set_buf = {32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555};
		send_set();
		set_buf = {32'h3, 32'h4, 32'h4, 32'h3, 32'h3};
		send_set();
		wait_drained();

		// receiver holds off while the sender keeps offering
		@(negedge clk);
		hold_req = ~hold_req;
		send_random(150);
		wait_drained();

		run_phase(0, 0);
		run_phase(64, 0);
		run_phase(0, 64);
		run_phase(30, 30);

		repeat (SETTLE) @(negedge clk);
		if (fails == 0 && majority_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/maj_pkg.sv
hw/rtl/maj_store.sv
hw/rtl/maj_tally.sv
hw/rtl/majority_element_finder_top.sv
hw/rtl/majority_element_finder_chk.sv
bench/tb_top.sv
